/* design/dmip_pkg.sv */
// Shared types, constants and helper functions for the dual motor PID controller.
`timescale 1ns / 1ps

package dmip_pkg;

  typedef logic [13:0]        duty_t;
  typedef logic [12:0]        target_t;
  typedef logic [9:0]         speed_t;
  typedef logic [4:0]         level_t;
  typedef logic signed [15:0] err_t;
  typedef logic signed [19:0] acc_t;

  localparam duty_t   DutyBase  = 14'd6100;
  localparam duty_t   DutyMax   = 14'd8800;
  localparam duty_t   DutyKick  = 14'd6500;
  localparam logic [15:0] StopTime = 16'd1000;
  localparam logic [7:0]  LossRows = 8'd40;
  localparam speed_t  StallSpeed = 10'd50;
  localparam speed_t  KickSpeed  = 10'd100;
  localparam logic [7:0]  BrakeSettle = 8'd3;

  // Target speed for a dip switch level; undefined levels give zero.
  function automatic target_t level_target(input level_t level);
    target_t t;
    case (level)
      5'd0:    t = 13'd3800;
      5'd1:    t = 13'd4000;
      5'd2:    t = 13'd4400;
      5'd3:    t = 13'd4600;
      5'd4:    t = 13'd4800;
      5'd5:    t = 13'd5000;
      5'd6:    t = 13'd5100;
      default: t = 13'd0;
    endcase
    return t;
  endfunction

  // Halve, truncating toward zero.
  function automatic acc_t half_to_zero(input acc_t x);
    acc_t b;
    b = x + $signed({19'd0, x[19]});
    return b >>> 1;
  endfunction

endpackage

/* design/dmip_wheel.sv */
// One wheel's incremental PID: error history and clamped duty.
`timescale 1ns / 1ps

module dmip_wheel (
  input  logic              clk,
  input  logic              rst,
  input  dmip_pkg::target_t target,
  input  dmip_pkg::speed_t  speed,
  input  logic              update,
  output dmip_pkg::duty_t   duty
);

  dmip_pkg::err_t err_prev;
  dmip_pkg::err_t err_prev2;

  logic [19:0]    meas_x10;
  dmip_pkg::acc_t err_now;
  dmip_pkg::acc_t e1;
  dmip_pkg::acc_t e2;
  dmip_pkg::acc_t de;
  dmip_pkg::acc_t d2e;
  dmip_pkg::acc_t sum;

  always_comb begin
    meas_x10 = {10'd0, speed} * 20'd10;
    err_now  = $signed({7'd0, target}) - $signed(meas_x10);
    e1       = {{4{err_prev[15]}}, err_prev};
    e2       = {{4{err_prev2[15]}}, err_prev2};
    de       = err_now - e1;
    d2e      = err_now - (e1 <<< 1) + e2;
    // Proportional term 20*de/10 is exact; the other two halve toward zero.
    sum      = $signed({6'd0, dmip_pkg::DutyBase}) + (de <<< 1)
             + dmip_pkg::half_to_zero(err_now) + dmip_pkg::half_to_zero(d2e);
    if (sum[19]) begin
      duty = '0;
    end else if (sum > $signed({6'd0, dmip_pkg::DutyMax})) begin
      duty = dmip_pkg::DutyMax;
    end else begin
      duty = sum[13:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      err_prev  <= '0;
      err_prev2 <= '0;
    end else if (update) begin
      err_prev2 <= err_prev;
      err_prev  <= err_now[15:0];
    end
  end

endmodule

/* design/dual_motor_incremental_pid_top.sv */
// Top level of the two-wheel incremental PID speed controller.
`timescale 1ns / 1ps

// Two-wheel incremental PID speed controller. Each transaction on the input
// channel is either a control tick or a brake pulse and yields exactly one
// transaction on the output channel carrying both wheel duties (0..8800).
// A transaction is captured in an input register and its result is written
// from there into the output register, and one transaction is taken every
// cycle while the consumer keeps taking results. The rate is set by the
// state loop: error history, held duties and the brake counter are updated
// by the same edge that loads the output register, so the next transaction
// always sees the state left by the one before. The speed level register is
// written through the configuration channel, which is always ready; write it
// only while no transaction is in flight. Line loss (40 or more black rows)
// zeroes the held duties, a running brake counter holds them for a few ticks,
// and the stall stop rule or the low-speed kick may override either wheel.
module dual_motor_incremental_pid_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [9:0]  speed_right,
  input  logic [9:0]  speed_left,
  input  logic [7:0]  black_rows,
  input  logic        stop_request,
  input  logic [15:0] elapsed_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [13:0] duty_right,
  output logic [13:0] duty_left
);

  dmip_pkg::level_t speed_level;

  // Input register
  logic             s1_valid;
  logic             s1_req;
  dmip_pkg::speed_t s1_sr;
  dmip_pkg::speed_t s1_sl;
  logic [7:0]       s1_rows;
  logic             s1_stop;
  logic [15:0]      s1_time;

  // Controller state
  dmip_pkg::duty_t  held_duty_right;
  dmip_pkg::duty_t  held_duty_left;
  logic [7:0]       brake_count;

  logic             advance;
  logic             pid_update;
  dmip_pkg::target_t target;
  dmip_pkg::duty_t  pid_right;
  dmip_pkg::duty_t  pid_left;
  dmip_pkg::duty_t  dr_next;
  dmip_pkg::duty_t  dl_next;
  logic [7:0]       brake_count_next;
  logic             stall_r;
  logic             stall_l;

  assign cfg_ready = 1'b1;

  // Move the held transaction on whenever the output register is free.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_level <= '0;
    end else if (cfg_valid && cfg_ready) begin
      speed_level <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req  <= req_type;
      s1_sr   <= speed_right;
      s1_sl   <= speed_left;
      s1_rows <= black_rows;
      s1_stop <= stop_request;
      s1_time <= elapsed_time;
    end
  end

  assign target = dmip_pkg::level_target(speed_level);

  dmip_wheel u_wheel_right (
    .clk    (clk),
    .rst    (rst),
    .target (target),
    .speed  (s1_sr),
    .update (pid_update),
    .duty   (pid_right)
  );

  dmip_wheel u_wheel_left (
    .clk    (clk),
    .rst    (rst),
    .target (target),
    .speed  (s1_sl),
    .update (pid_update),
    .duty   (pid_left)
  );

  always_comb begin
    stall_r          = s1_sr < dmip_pkg::StallSpeed;
    stall_l          = s1_sl < dmip_pkg::StallSpeed;
    pid_update       = 1'b0;
    brake_count_next = brake_count;
    dr_next          = held_duty_right;
    dl_next          = held_duty_left;

    if (s1_req) begin
      // Brake pulse: bump the counter and leave the duties held.
      brake_count_next = brake_count + 8'd1;
    end else begin
      if (s1_rows >= dmip_pkg::LossRows) begin
        dr_next = '0;
        dl_next = '0;
      end else if (brake_count == 8'd0) begin
        pid_update = advance;
        dr_next    = pid_right;
        dl_next    = pid_left;
      end else if (brake_count < dmip_pkg::BrakeSettle) begin
        brake_count_next = brake_count + 8'd1;
      end else begin
        brake_count_next = '0;
      end

      // Stall stop rule first, otherwise kick a slow wheel pair.
      if ((stall_l || stall_r) && s1_stop && (s1_time > dmip_pkg::StopTime)) begin
        if (stall_l) dl_next = '0;
        if (stall_r) dr_next = '0;
      end else if ((s1_sr < dmip_pkg::KickSpeed) || (s1_sl < dmip_pkg::KickSpeed)) begin
        dr_next = dmip_pkg::DutyKick;
        dl_next = dmip_pkg::DutyKick;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_duty_right <= '0;
      held_duty_left  <= '0;
      brake_count     <= '0;
    end else if (advance) begin
      brake_count <= brake_count_next;
      if (!s1_req) begin
        held_duty_right <= dr_next;
        held_duty_left  <= dl_next;
      end
    end
  end

  // Output register: hold the result until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      duty_right <= s1_req ? '0 : dr_next;
      duty_left  <= s1_req ? '0 : dl_next;
    end
  end

  // A result never leaves the duty range.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (duty_right <= dmip_pkg::DutyMax) && (duty_left <= dmip_pkg::DutyMax))
    else $error("duty out of range");

  // A brake pulse drives both wheels to zero.
  assert property (@(posedge clk) disable iff (rst)
    advance && s1_req |=> out_valid && (duty_right == '0) && (duty_left == '0))
    else $error("brake pulse did not zero the duties");

  // A brake pulse advances the brake counter by one.
  assert property (@(posedge clk) disable iff (rst)
    advance && s1_req |=> brake_count == $past(brake_count) + 8'd1)
    else $error("brake counter did not advance");

  // A brake pulse leaves the held duties alone.
  assert property (@(posedge clk) disable iff (rst)
    advance && s1_req |=> $stable(held_duty_right) && $stable(held_duty_left))
    else $error("held duties changed on brake pulse");

  // An empty input register always takes a new transaction.
  assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input stalled while empty");

endmodule
